@@ hdl/mscell_pkg.sv @@
// mscell_pkg: types, widths and the marching-squares case table for the cell block
// no dependencies; imported by marching_squares_cell
package mscell_pkg;

  localparam int WW      = 32;  // weight and coordinate width
  localparam int CSW     = 24;  // cell size width
  localparam int IDXW    = 8;   // cell index width
  localparam int PRODW   = WW + CSW;
  localparam int DIV_STG = CSW; // one quotient bit per stage

  localparam logic [1:0] EDGE_LEFT   = 2'd0;
  localparam logic [1:0] EDGE_BOTTOM = 2'd1;
  localparam logic [1:0] EDGE_RIGHT  = 2'd2;
  localparam logic [1:0] EDGE_TOP    = 2'd3;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_CELL_SIZE = 1'b1;

  // per-point data carried alongside the arithmetic
  typedef struct packed {
    logic [1:0]    edge_id;
    logic          last;
    logic          zero_f;  // equal edge weights
    logic          clamp_f; // offset reaches the full cell size
    logic [WW-1:0] base_x;
    logic [WW-1:0] base_y;
  } meta_t;

  typedef struct packed {
    logic            vld;
    meta_t           meta;
    logic [WW-1:0]   rem;
    logic [CSW-1:0]  low;
    logic [CSW-1:0]  quo;
    logic [WW-1:0]   den;
  } div_stage_t;

  // number of points for a case code
  function automatic logic [2:0] case_count(input logic [3:0] code);
    logic [2:0] n;
    unique case (code)
      4'd0, 4'd15: n = 3'd0;
      4'd5, 4'd10: n = 3'd4;
      default:     n = 3'd2;
    endcase
    return n;
  endfunction

  // edge of point k for a case code
  function automatic logic [1:0] case_edge(input logic [3:0] code, input logic [1:0] k);
    logic [7:0] row;
    unique case (code)
      4'd1, 4'd14: row = {EDGE_LEFT,   EDGE_LEFT,   EDGE_BOTTOM, EDGE_LEFT};
      4'd2, 4'd13: row = {EDGE_LEFT,   EDGE_LEFT,   EDGE_RIGHT,  EDGE_BOTTOM};
      4'd3, 4'd12: row = {EDGE_LEFT,   EDGE_LEFT,   EDGE_RIGHT,  EDGE_LEFT};
      4'd4, 4'd11: row = {EDGE_LEFT,   EDGE_LEFT,   EDGE_TOP,    EDGE_RIGHT};
      4'd5:        row = {EDGE_RIGHT,  EDGE_BOTTOM, EDGE_TOP,    EDGE_LEFT};
      4'd6, 4'd9:  row = {EDGE_LEFT,   EDGE_LEFT,   EDGE_TOP,    EDGE_BOTTOM};
      4'd7, 4'd8:  row = {EDGE_LEFT,   EDGE_LEFT,   EDGE_TOP,    EDGE_LEFT};
      4'd10:       row = {EDGE_TOP,    EDGE_RIGHT,  EDGE_BOTTOM, EDGE_LEFT};
      default:     row = {EDGE_LEFT,   EDGE_LEFT,   EDGE_LEFT,   EDGE_LEFT};
    endcase
    return row[k*2 +: 2];
  endfunction

endpackage

@@ hdl/marching_squares_cell.sv @@
// marching_squares_cell: isoline edge points of one grid cell, fully pipelined
// depends on mscell_pkg (types, case table)

// One request carries a cell's four corner weights and its column and row; the
// block answers with zero, two or four points, one per cycle unless out_ready
// holds the pipeline, in segment order, with out_last on the final one. The
// next cell is taken as soon as the last point of the previous one leaves the
// point issue stage; an empty cell never occupies that stage. The path from
// issue to output runs through operand select, multiply, a 24-stage restoring
// divider (one quotient bit per stage) and the grid offset add with saturation.
// Back-pressure on out_ready holds the whole pipeline. Write threshold and cell
// size only while the block is idle.
module marching_squares_cell
  import mscell_pkg::*;
#(
  parameter int GRID_DIM = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WW-1:0]    in_weight_bottom_left,
  input  logic [WW-1:0]    in_weight_bottom_right,
  input  logic [WW-1:0]    in_weight_top_right,
  input  logic [WW-1:0]    in_weight_top_left,
  input  logic [IDXW-1:0]  in_cell_col,
  input  logic [IDXW-1:0]  in_cell_row,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WW-1:0]    out_point_x,
  output logic [WW-1:0]    out_point_y,
  output logic [1:0]       out_edge_res,
  output logic             out_last,
  input  logic             cfg_we,
  input  logic             cfg_idx,
  input  logic [WW-1:0]    cfg_wdata
);

  localparam logic [IDXW-1:0] CELL_LIM = IDXW'(GRID_DIM - 2);

  // configuration registers
  logic [WW-1:0]  threshold_r;
  logic [CSW-1:0] cell_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= WW'(65536);
      cell_size_r <= CSW'(19661);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_THRESHOLD: threshold_r <= cfg_wdata;
        CFG_CELL_SIZE: cell_size_r <= cfg_wdata[CSW-1:0];
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves unless the output is held
  logic adv;
  assign adv = !out_valid || out_ready;

  // point issue stage: holds one cell, walks its points
  logic            em_valid_r;
  logic [WW-1:0]   em_w_r [4];
  logic [IDXW-1:0] em_col_r, em_row_r;
  logic [3:0]      em_code_r;
  logic [1:0]      em_k_r;
  logic [2:0]      em_cnt_r;
  logic            em_last;
  logic [3:0]      in_code;
  logic [2:0]      in_cnt;
  logic            in_take;

  assign em_last  = ({1'b0, em_k_r} + 3'd1) == em_cnt_r;
  assign in_ready = !em_valid_r || (adv && em_last);
  assign in_take  = in_valid && in_ready;

  always_comb begin
    in_code[0] = in_weight_bottom_left  >= threshold_r;
    in_code[1] = in_weight_bottom_right >= threshold_r;
    in_code[2] = in_weight_top_right    >= threshold_r;
    in_code[3] = in_weight_top_left     >= threshold_r;
    in_cnt     = case_count(in_code);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_valid_r <= 1'b0;
    end else if (in_take) begin
      em_valid_r <= in_cnt != 3'd0;
    end else if (adv && em_last) begin
      em_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      em_w_r[0] <= in_weight_bottom_left;
      em_w_r[1] <= in_weight_bottom_right;
      em_w_r[2] <= in_weight_top_right;
      em_w_r[3] <= in_weight_top_left;
      em_col_r  <= (in_cell_col > CELL_LIM) ? CELL_LIM : in_cell_col;
      em_row_r  <= (in_cell_row > CELL_LIM) ? CELL_LIM : in_cell_row;
      em_code_r <= in_code;
      em_cnt_r  <= in_cnt;
      em_k_r    <= 2'd0;
    end else if (adv && em_valid_r) begin
      em_k_r <= em_k_r + 2'd1;
    end
  end

  // operand select for the current point
  logic [1:0]    em_edge;
  logic [WW-1:0] wa, wb, num, den;

  always_comb begin
    em_edge = case_edge(em_code_r, em_k_r);
    unique case (em_edge)
      EDGE_LEFT:   begin wa = em_w_r[0]; wb = em_w_r[3]; end
      EDGE_BOTTOM: begin wa = em_w_r[0]; wb = em_w_r[1]; end
      EDGE_RIGHT:  begin wa = em_w_r[1]; wb = em_w_r[2]; end
      default:     begin wa = em_w_r[3]; wb = em_w_r[2]; end
    endcase
    num = (wa >= threshold_r) ? wa - threshold_r : threshold_r - wa;
    den = (wa >= wb) ? wa - wb : wb - wa;
  end

  // stage a: operands registered
  logic            pa_vld_r;
  logic [1:0]      pa_edge_r;
  logic            pa_last_r;
  logic [WW-1:0]   pa_num_r, pa_den_r;
  logic [IDXW-1:0] pa_col_r, pa_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_vld_r <= 1'b0;
    end else if (adv) begin
      pa_vld_r <= em_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_edge_r <= em_edge;
      pa_last_r <= em_last;
      pa_num_r  <= num;
      pa_den_r  <= den;
      pa_col_r  <= em_col_r;
      pa_row_r  <= em_row_r;
    end
  end

  // stage b: cell size times numerator, grid base offsets
  logic             pb_vld_r;
  meta_t            pb_meta_r;
  logic [PRODW-1:0] pb_prod_r;
  logic [WW-1:0]    pb_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pb_vld_r <= 1'b0;
    end else if (adv) begin
      pb_vld_r <= pa_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pb_prod_r         <= PRODW'(cell_size_r) * PRODW'(pa_num_r);
      pb_den_r          <= pa_den_r;
      pb_meta_r.edge_id <= pa_edge_r;
      pb_meta_r.last    <= pa_last_r;
      pb_meta_r.zero_f  <= pa_den_r == '0;
      pb_meta_r.clamp_f <= pa_num_r >= pa_den_r;
      pb_meta_r.base_x  <= WW'(pa_col_r) * WW'(cell_size_r);
      pb_meta_r.base_y  <= WW'(pa_row_r) * WW'(cell_size_r);
    end
  end

  // restoring divider, one quotient bit per stage
  div_stage_t dv_r [DIV_STG+1];
  div_stage_t dv_nxt [DIV_STG+1];

  always_comb begin
    dv_nxt[0].vld  = pb_vld_r;
    dv_nxt[0].meta = pb_meta_r;
    dv_nxt[0].rem  = pb_prod_r[PRODW-1:CSW];
    dv_nxt[0].low  = pb_prod_r[CSW-1:0];
    dv_nxt[0].quo  = '0;
    dv_nxt[0].den  = pb_den_r;
  end

  for (genvar i = 0; i < DIV_STG; i++) begin : g_div
    logic [WW:0] trial;
    logic        ge;
    always_comb begin
      trial = {dv_r[i].rem, dv_r[i].low[CSW-1]};
      ge    = trial >= {1'b0, dv_r[i].den};
      dv_nxt[i+1]      = dv_r[i];
      dv_nxt[i+1].rem  = ge ? WW'(trial - {1'b0, dv_r[i].den}) : trial[WW-1:0];
      dv_nxt[i+1].low  = {dv_r[i].low[CSW-2:0], 1'b0};
      dv_nxt[i+1].quo  = {dv_r[i].quo[CSW-2:0], ge};
    end
  end

  // divider stage registers, only the valid bits are reset
  always_ff @(posedge clk) begin
    for (int i = 0; i <= DIV_STG; i++) begin
      if (!rst_n) begin
        dv_r[i].vld <= 1'b0;
      end else if (adv) begin
        dv_r[i].vld <= dv_nxt[i].vld;
      end
      if (adv) begin
        dv_r[i].meta <= dv_nxt[i].meta;
        dv_r[i].rem  <= dv_nxt[i].rem;
        dv_r[i].low  <= dv_nxt[i].low;
        dv_r[i].quo  <= dv_nxt[i].quo;
        dv_r[i].den  <= dv_nxt[i].den;
      end
    end
  end

  // offset select, grid add and saturation
  meta_t          fm;
  logic [CSW-1:0] offs;
  logic [WW:0]    sum_x, sum_y;
  logic [WW-1:0]  px_nxt, py_nxt;

  always_comb begin
    fm = dv_r[DIV_STG].meta;
    priority if (fm.zero_f) offs = '0;
    else if (fm.clamp_f)    offs = cell_size_r;
    else                    offs = dv_r[DIV_STG].quo;
    unique case (fm.edge_id)
      EDGE_LEFT: begin
        sum_x = {1'b0, fm.base_x};
        sum_y = {1'b0, fm.base_y} + (WW+1)'(offs);
      end
      EDGE_BOTTOM: begin
        sum_x = {1'b0, fm.base_x} + (WW+1)'(offs);
        sum_y = {1'b0, fm.base_y};
      end
      EDGE_RIGHT: begin
        sum_x = {1'b0, fm.base_x} + (WW+1)'(cell_size_r);
        sum_y = {1'b0, fm.base_y} + (WW+1)'(offs);
      end
      default: begin
        sum_x = {1'b0, fm.base_x} + (WW+1)'(offs);
        sum_y = {1'b0, fm.base_y} + (WW+1)'(cell_size_r);
      end
    endcase
    px_nxt = sum_x[WW] ? '1 : sum_x[WW-1:0];
    py_nxt = sum_y[WW] ? '1 : sum_y[WW-1:0];
  end

  // output register
  logic          out_valid_r;
  logic [WW-1:0] out_x_r, out_y_r;
  logic [1:0]    out_edge_r;
  logic          out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_r[DIV_STG].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r    <= px_nxt;
      out_y_r    <= py_nxt;
      out_edge_r <= fm.edge_id;
      out_last_r <= fm.last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_point_x  = out_x_r;
  assign out_point_y  = out_y_r;
  assign out_edge_res = out_edge_r;
  assign out_last     = out_last_r;

endmodule
